[hdl/assert_macros.svh]
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every sampled edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: always");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implies");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/nsv_pkg.sv]
package nsv_pkg;

  localparam int CHAR_W = 16;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 16'h002B;
  localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;

  localparam logic [2:0] COMMA_GAP = 3'd4;
  localparam logic [2:0] SINCE_MAX = 3'd5;
  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_SAT   = 2'd2;

  typedef enum logic [2:0] {
    KIND_DIGIT,
    KIND_DOT,
    KIND_SIGN,
    KIND_COMMA,
    KIND_OTHER
  } char_kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } char_item_t;

  typedef struct packed {
    logic [1:0] position;
    logic       first_was_zero;
    logic       first_was_sign;
    logic       sign_then_nondigit;
    logic       dot_seen;
    logic       comma_seen;
    logic [2:0] since_comma;
    logic       failed;
  } token_state_t;

  function automatic char_kind_t classify(input logic [CHAR_W-1:0] c);
    char_kind_t k;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      k = KIND_DIGIT;
    end else if (c == CH_DOT) begin
      k = KIND_DOT;
    end else if (c == CH_MINUS || c == CH_PLUS) begin
      k = KIND_SIGN;
    end else if (c == CH_COMMA) begin
      k = KIND_COMMA;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

[hdl/nsv_char_if.sv]
interface nsv_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        last_char;

  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

[hdl/nsv_result_if.sv]
interface nsv_result_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source(output valid, output is_valid, input ready);
  modport sink(input valid, input is_valid, output ready);
endinterface

[hdl/nsv_in_reg.sv]
module nsv_in_reg import nsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  char_item_t item,
  input  logic       take,
  output logic       held_valid,
  output char_item_t held
);

  assign item_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

[hdl/nsv_rules.sv]
`include "assert_macros.svh"

module nsv_rules import nsv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  char_item_t item,
  input  logic       fire,
  output logic       token_ok
);

  token_state_t st;
  token_state_t st_next;
  char_kind_t   kind;
  logic [2:0]   spacing;

  assign kind = classify(item.char_code);
  assign spacing = (st.since_comma >= SINCE_MAX) ? SINCE_MAX : st.since_comma + 3'd1;

  always_comb begin
    st_next  = st;
    token_ok = 1'b0;

    if (st.position == POS_FIRST) begin
      st_next.first_was_zero = (item.char_code == CH_ZERO);
      st_next.first_was_sign = (kind == KIND_SIGN);
    end else if (st.position == POS_SECOND) begin
      if (st.first_was_zero && kind != KIND_DOT) begin
        st_next.failed = 1'b1;
      end
      if (st.first_was_sign && kind != KIND_DIGIT) begin
        st_next.sign_then_nondigit = 1'b1;
      end
    end

    st_next.since_comma = spacing;
    case (kind)
      KIND_DIGIT: begin
      end
      KIND_DOT: begin
        if (st.position == POS_FIRST || st.dot_seen) begin
          st_next.failed = 1'b1;
        end
        st_next.dot_seen = 1'b1;
      end
      KIND_SIGN: begin
        if (st.position != POS_FIRST) begin
          st_next.failed = 1'b1;
        end
      end
      KIND_COMMA: begin
        if (st.position == POS_FIRST || item.last_char) begin
          st_next.failed = 1'b1;
        end
        if (st.comma_seen && spacing != COMMA_GAP) begin
          st_next.failed = 1'b1;
        end
        st_next.comma_seen  = 1'b1;
        st_next.since_comma = 3'd0;
      end
      default: begin
        st_next.failed = 1'b1;
      end
    endcase

    // a lone character must be a digit
    if (kind != KIND_DIGIT && item.last_char && st.position == POS_FIRST) begin
      st_next.failed = 1'b1;
    end

    if (item.last_char) begin
      token_ok = !(st_next.failed ||
                   (st.position >= POS_SAT && st_next.sign_then_nondigit));
      st_next  = '0;
    end else if (st.position < POS_SAT) begin
      st_next.position = st.position + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  `ASSERT_ALWAYS(a_pos_sat, clk, rst, st.position <= POS_SAT)
  `ASSERT_ALWAYS(a_since_sat, clk, rst, st.since_comma <= SINCE_MAX)
  `ASSERT_NEXT(a_clear_after_last, clk, rst, fire && item.last_char,
               st.position == POS_FIRST && !st.failed && !st.comma_seen)

endmodule

[hdl/nsv_out_reg.sv]
module nsv_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic result_in,
  output logic room,
  output logic result_valid,
  input  logic result_ready,
  output logic result
);

  assign room = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

[hdl/numeric_string_validator_core.sv]
// numeric token checker
// token: one 16-bit character per transaction, last_char set on the final
//   character of a token; tokens follow each other with no gap needed
// verdict: one transaction per token, is_valid high when every rule held
// a character goes from the token channel into an input register, the rule
//   logic updates the token state from it, and a last character loads the
//   result register
// the verdict is registered: a last character passes the input register and
//   then loads the result register once that register has room
// throughput: one character per cycle while no final character waits for the
//   result register, set by the single pass of rule logic between the input register and the token state
// a stalled verdict channel holds the result register; the input register
//   keeps taking non-final characters, and a final character waits there,
//   holding the token channel off, until the result register frees up
// reset clears the token state and both valid flags; the block is ready to
//   take a character once reset is released
`include "assert_macros.svh"

module numeric_string_validator_core import nsv_pkg::*; (
  input logic           clk,
  input logic           rst,
  nsv_char_if.sink      token,
  nsv_result_if.source  verdict
);

  char_item_t in_item;
  char_item_t held;
  logic       held_valid;
  logic       room;
  logic       consume;
  logic       token_ok;
  logic       load;

  assign in_item.char_code = token.char_code;
  assign in_item.last_char = token.last_char;

  // a final character needs space in the result register
  assign consume = held_valid && (!held.last_char || room);
  assign load    = consume && held.last_char;

  nsv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (token.valid),
    .item_ready (token.ready),
    .item       (in_item),
    .take       (consume),
    .held_valid (held_valid),
    .held       (held)
  );

  nsv_rules u_rules (
    .clk      (clk),
    .rst      (rst),
    .item     (held),
    .fire     (consume),
    .token_ok (token_ok)
  );

  nsv_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .result_in    (token_ok),
    .room         (room),
    .result_valid (verdict.valid),
    .result_ready (verdict.ready),
    .result       (verdict.is_valid)
  );

  `ASSERT_NEXT(a_last_gives_verdict, clk, rst, load, verdict.valid)
  `ASSERT_NEXT(a_no_spurious_verdict, clk, rst, !verdict.valid && !load, !verdict.valid)
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, verdict.valid && !verdict.ready, !load)

endmodule

[test/nsv_verdict_checker.sv]
module nsv_verdict_checker import nsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  nsv_char_if    token,
  nsv_result_if  verdict,
  output int     fails,
  output int     pending,
  output int     judged,
  output int     judged_valid
);

  token_state_t rules;
  bit           verdict_q[$];

  // walk one character through the token rules, queue a verdict on the last one
  task automatic judge_char(input logic [CHAR_W-1:0] c, input logic last);
    logic [1:0] pos;
    logic       digit;
    logic       sign;
    logic [2:0] spacing;
    pos     = rules.position;
    digit   = (c >= CH_ZERO) && (c <= CH_NINE);
    sign    = (c == CH_MINUS) || (c == CH_PLUS);
    spacing = (rules.since_comma >= SINCE_MAX) ? SINCE_MAX : rules.since_comma + 3'd1;

    if (pos == POS_FIRST) begin
      rules.first_was_zero = (c == CH_ZERO);
      rules.first_was_sign = sign;
    end else if (pos == POS_SECOND) begin
      if (rules.first_was_zero && c != CH_DOT) rules.failed = 1'b1;
      if (rules.first_was_sign && !digit) rules.sign_then_nondigit = 1'b1;
    end

    if (!digit) begin
      if (c == CH_DOT) begin
        if (pos == POS_FIRST || rules.dot_seen) rules.failed = 1'b1;
        rules.dot_seen = 1'b1;
      end else if (sign) begin
        if (pos != POS_FIRST) rules.failed = 1'b1;
      end else if (c == CH_COMMA) begin
        if (pos == POS_FIRST || last) rules.failed = 1'b1;
        if (rules.comma_seen && spacing != COMMA_GAP) rules.failed = 1'b1;
        rules.comma_seen = 1'b1;
        spacing = 3'd0;
      end else begin
        rules.failed = 1'b1;
      end
      // a lone non-digit never passes
      if (last && pos == POS_FIRST) rules.failed = 1'b1;
    end
    rules.since_comma = spacing;

    if (!last) begin
      if (rules.position != POS_SAT) rules.position = rules.position + 2'd1;
    end else begin
      // sign then non-digit only matters for tokens of three or more characters
      if (pos == POS_SAT && rules.sign_then_nondigit) rules.failed = 1'b1;
      verdict_q.push_back(!rules.failed);
      rules = '0;
    end
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      rules = '0;
      verdict_q.delete();
    end else begin
      // verdict first: it belongs to a token whose last character was taken earlier
      if (verdict.valid && verdict.ready) begin
        if (verdict_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("verdict %0b at %0t with no token pending", verdict.is_valid, $time);
        end else begin
          want = verdict_q.pop_front();
          judged++;
          if (verdict.is_valid === 1'b1) judged_valid++;
          if (verdict.is_valid !== want) begin
            fails++;
            if (fails <= 10)
              $display("token %0d: is_valid expected %0b, got %0b at %0t",
                       judged, want, verdict.is_valid, $time);
          end
        end
      end
      if (token.valid && token.ready) judge_char(token.char_code, token.last_char);
    end
    pending = verdict_q.size();
  end

endmodule

[test/numeric_string_validator_core_tb.sv]
module numeric_string_validator_core_tb;
  import nsv_pkg::*;

  localparam int CHAR_TARGET = 1750;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;

  nsv_char_if   token_ch ();
  nsv_result_if verdict_ch ();

  int fails;
  int pending;
  int judged;
  int judged_valid;

  int chars_sent;
  int tokens_sent;
  int cycles;
  int stall_left;
  bit idle_mode;
  bit quiet;
  bit drained_mid;

  logic [CHAR_W-1:0] tok[$];

  numeric_string_validator_core DUT (
    .clk     (clk),
    .rst     (rst),
    .token   (token_ch),
    .verdict (verdict_ch)
  );

  nsv_verdict_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .token        (token_ch),
    .verdict      (verdict_ch),
    .fails        (fails),
    .pending      (pending),
    .judged       (judged),
    .judged_valid (judged_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("numeric_string_validator_core_tb: done, errors");
      $finish;
    end
  end

  // verdict side back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      verdict_ch.ready <= 1'b0;
    end else if (!quiet && idle_mode && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      verdict_ch.ready <= 1'b0;
    end else begin
      verdict_ch.ready <= 1'b1;
    end
  end

  function automatic logic [CHAR_W-1:0] any_digit();
    return CH_ZERO + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return any_digit();
      4: return CH_DOT;
      5: return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
      6: return CH_COMMA;
      7: return CH_ZERO;
      8: return CHAR_W'($urandom_range(0, 65535));
      default: return CHAR_W'($urandom_range(0, 127));
    endcase
  endfunction

  // mostly well-formed numbers, some noise tokens, occasional single corruption
  function automatic void build_token();
    int n;
    tok.delete();
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) n = $urandom_range(7, 40);
      repeat (n) tok.push_back(any_char());
      return;
    end
    if ($urandom_range(0, 3) == 0) tok.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    if ($urandom_range(0, 5) == 0) begin
      tok.push_back(CH_ZERO);
      if ($urandom_range(0, 3) != 0) begin
        tok.push_back(CH_DOT);
        repeat ($urandom_range(0, 4)) tok.push_back(any_digit());
      end
    end else begin
      tok.push_back(CH_ZERO + CHAR_W'($urandom_range(1, 9)));
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(0, 2)) tok.push_back(any_digit());
        repeat ($urandom_range(1, 3)) begin
          tok.push_back(CH_COMMA);
          // group sizes other than three break the comma spacing when another comma follows
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 3;
          repeat (n) tok.push_back(any_digit());
        end
      end else begin
        repeat ($urandom_range(0, 7)) tok.push_back(any_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
        tok.push_back(CH_DOT);
        repeat ($urandom_range(1, 5)) tok.push_back(any_digit());
      end
    end
    if ($urandom_range(0, 7) == 0) tok[$urandom_range(0, tok.size() - 1)] = any_char();
  endfunction

  task automatic send_token();
    foreach (tok[i]) begin
      if (!quiet && idle_mode && $urandom_range(0, 4) == 0) begin
        token_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      token_ch.valid     <= 1'b1;
      token_ch.char_code <= tok[i];
      token_ch.last_char <= (i == tok.size() - 1);
      @(posedge clk);
      while (!token_ch.ready) @(posedge clk);
      chars_sent++;
    end
    tokens_sent++;
  endtask

  task automatic send_text(input string s);
    tok.delete();
    foreach (s[i]) tok.push_back({8'h00, s[i]});
    send_token();
  endtask

  task automatic drain();
    token_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    rst                <= 1'b1;
    token_ch.valid     <= 1'b0;
    token_ch.char_code <= '0;
    token_ch.last_char <= 1'b0;
    idle_mode          <= 1'b1;
    quiet              <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_text("7");
    send_text(".");
    send_text("-.");
    send_text("0");
    send_text("05");
    send_text("0.");
    send_text("-.5");
    send_text("1,234,5");
    send_text("+1,2");
    send_text("1.2.");
    tok = '{16'hFFFF};
    send_token();
    tok = '{16'h0000};
    send_token();
    drain();

    while (chars_sent < CHAR_TARGET) begin
      if ($urandom_range(0, 9) == 0) idle_mode <= !idle_mode;
      if (chars_sent >= CHAR_TARGET * 7 / 8) quiet <= 1'b1;
      if (!drained_mid && chars_sent >= CHAR_TARGET / 2) begin
        drained_mid = 1'b1;
        drain();
      end
      build_token();
      send_token();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d tokens in %0d characters sent, %0d verdicts checked, %0d of them valid",
             tokens_sent, chars_sent, judged, judged_valid);
    $display("bursty idling on both channels, drains after directed part and mid-run");
    if (fails == 0 && pending == 0) begin
      $display("numeric_string_validator_core_tb: done, clean");
    end else begin
      $display("numeric_string_validator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/nsv_pkg.sv
hdl/nsv_char_if.sv
hdl/nsv_result_if.sv
hdl/nsv_in_reg.sv
hdl/nsv_rules.sv
hdl/nsv_out_reg.sv
hdl/numeric_string_validator_core.sv
test/nsv_verdict_checker.sv
test/numeric_string_validator_core_tb.sv
